/* design/sri_pkg.sv */
// ----------------------------------------------------------------------------
// sri_pkg: shared definitions for the schedule ramp intensity block
// Day length, datapath widths, trigger modes, register indexes and the
// payload structs that travel down the cell chains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sri_pkg;

  // Length of the day in minutes.
  localparam int MIN_PER_DAY = 1440;
  // Highest percent level.
  localparam int PCT_MAX     = 100;

  // Field widths.
  localparam int MIN_W  = 11;   // minute of the day
  localparam int SUN_W  = 12;   // signed sun time
  localparam int REG_W  = 16;   // configuration data
  localparam int PCT_W  = 7;    // percent level
  localparam int IDX_W  = 3;    // configuration index

  // Sun time plus offset is biased by a whole number of days so it is never
  // negative before the modulo reduction.
  localparam int SUN_BIAS   = ((32768 + MIN_PER_DAY - 1) / MIN_PER_DAY) * MIN_PER_DAY;
  localparam int PRE_W      = 17;  // holds fixed minute or biased sun sum
  // Reduction cells: one conditional subtract of MIN_PER_DAY << k each.
  localparam int WRAP_CELLS = 6;
  // Ramp divider: one quotient bit per cell, quotient stays below PCT_MAX.
  localparam int DIV_CELLS  = PCT_W;
  localparam int PROD_W     = 18;  // percent difference times minutes

  // Trigger modes.
  typedef enum logic [1:0] {
    MODE_FIXED   = 2'd0,
    MODE_SUNRISE = 2'd1,
    MODE_SUNSET  = 2'd2,
    MODE_INVALID = 2'd3
  } sri_mode_t;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_TRIGGER_MODES = 3'd0,
    REG_START_FIXED   = 3'd1,
    REG_END_FIXED     = 3'd2,
    REG_START_OFFSET  = 3'd3,
    REG_END_OFFSET    = 3'd4,
    REG_LEVEL_PAIR    = 3'd5,
    REG_RAMP_UP       = 3'd6,
    REG_RAMP_DOWN     = 3'd7
  } sri_reg_t;

  // How the final level is picked.
  typedef enum logic [1:0] {
    LVL_OFF    = 2'd0,
    LVL_BASE   = 2'd1,
    LVL_TARGET = 2'd2,
    LVL_RAMP   = 2'd3
  } sri_lvl_t;

  // Trigger before the modulo reduction.
  typedef struct packed {
    logic             ok;
    logic [PRE_W-1:0] pre;
  } sri_pre_t;

  // Side data carried along the reduction chain.
  typedef struct packed {
    logic [MIN_W-1:0] now;
    logic             st_ok;
    logic             en_ok;
  } sri_wrap_side_t;

  // Resolved triggers as reported on the result channel.
  typedef struct packed {
    logic             st_valid;
    logic [MIN_W-1:0] st_minute;
    logic             en_valid;
    logic [MIN_W-1:0] en_minute;
  } sri_trig_t;

  // Side data carried along the divider chain.
  typedef struct packed {
    sri_lvl_t         kind;
    logic             neg;
    logic [PCT_W-1:0] base;
    logic [PCT_W-1:0] tgt;
    sri_trig_t        trig;
  } sri_lvl_side_t;

  // Clamp an 8-bit percent setting to PCT_MAX.
  function automatic logic [PCT_W-1:0] pct_clamp(input logic [7:0] v);
    return (v > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : v[PCT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/sri_wrap_cell.sv */
// ----------------------------------------------------------------------------
// sri_wrap_cell: one step of the modulo-day reduction
// Holds the start and end trigger values of one item and subtracts the day
// length shifted by SHIFT from each lane where it fits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sri_wrap_cell #(
  parameter int SHIFT = 0,
  parameter int SW    = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0][sri_pkg::PRE_W-1:0]        in_rem,
  input  logic [SW-1:0]                         in_side,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0][sri_pkg::PRE_W-1:0]        out_rem,
  output logic [SW-1:0]                         out_side
);
  import sri_pkg::*;

  localparam logic [PRE_W-1:0] SUB = PRE_W'(MIN_PER_DAY * (2 ** SHIFT));

  logic                    valid_r;
  logic [1:0][PRE_W-1:0]   rem_r;
  logic [1:0][PRE_W-1:0]   rem_nxt;
  logic [SW-1:0]           side_r;

  // The cell takes a new item whenever its own register is free or drains.
  assign in_ready = !valid_r || out_ready;

  // Conditional subtract in both lanes.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_nxt[i] = (in_rem[i] >= SUB) ? (in_rem[i] - SUB) : in_rem[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

/* design/sri_div_cell.sv */
// ----------------------------------------------------------------------------
// sri_div_cell: one stage of the restoring ramp divider
// Compares the partial remainder with the divisor shifted by SHIFT, subtracts
// where it fits and shifts the resulting quotient bit in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sri_div_cell #(
  parameter int SHIFT = 0,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sri_pkg::PROD_W-1:0]  in_rem,
  input  logic [sri_pkg::MIN_W-1:0]   in_div,
  input  logic [sri_pkg::PCT_W-1:0]   in_quo,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sri_pkg::PROD_W-1:0]  out_rem,
  output logic [sri_pkg::MIN_W-1:0]   out_div,
  output logic [sri_pkg::PCT_W-1:0]   out_quo,
  output logic [SW-1:0]               out_side
);
  import sri_pkg::*;

  logic                valid_r;
  logic [PROD_W-1:0]   rem_r;
  logic [PROD_W-1:0]   rem_nxt;
  logic [MIN_W-1:0]    div_r;
  logic [PCT_W-1:0]    quo_r;
  logic [PCT_W-1:0]    quo_nxt;
  logic [SW-1:0]       side_r;
  logic [PROD_W-1:0]   sub;
  logic                fits;

  assign in_ready = !valid_r || out_ready;

  // Trial subtract of the shifted divisor.
  always_comb begin
    sub     = PROD_W'(in_div) << SHIFT;
    fits    = (in_rem >= sub);
    rem_nxt = fits ? (in_rem - sub) : in_rem;
    quo_nxt = {in_quo[PCT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      div_r  <= in_div;
      quo_r  <= quo_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

/* design/schedule_ramp_intensity.sv */
// ----------------------------------------------------------------------------
// schedule_ramp_intensity: daily lighting window with linear level ramps
// Resolves start and end triggers per query and returns the window state,
// the ramped percent level and both resolved trigger minutes.
// ----------------------------------------------------------------------------
// Usage:
//   Queries enter on the in_ channel (valid/ready) and each gives exactly one
//   result on the out_ channel (valid/ready), in order. The block keeps no
//   state between queries; the cfg_ port writes the eight settings registers
//   and must only be used while no query is in flight.
// Throughput:
//   One query is taken every cycle while the receiver does not stall: the
//   datapath is a chain of registered cells, six for the modulo-day
//   reduction of the triggers and seven for the ramp divider (one quotient
//   bit each), with window and multiply stages between.
// Stalls:
//   Every stage has its own valid bit and moves when the next one is free, so
//   a stalled receiver only holds the final register; input keeps being taken
//   until all stages are full, and nothing is dropped or repeated.
// Reset:
//   rst_n is synchronous and active low. It empties the pipeline and clears
//   all settings registers to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module schedule_ramp_intensity (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration
  input  logic                                cfg_we,
  input  logic [sri_pkg::IDX_W-1:0]           cfg_index,
  input  logic [sri_pkg::REG_W-1:0]           cfg_wdata,
  // Query channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sri_pkg::MIN_W-1:0]           in_now_minute,
  input  logic signed [sri_pkg::SUN_W-1:0]    in_sunrise_minute,
  input  logic signed [sri_pkg::SUN_W-1:0]    in_sunset_minute,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_active,
  output logic [sri_pkg::PCT_W-1:0]           out_level_percent,
  output logic                                out_start_valid,
  output logic [sri_pkg::MIN_W-1:0]           out_start_minute,
  output logic                                out_end_valid,
  output logic [sri_pkg::MIN_W-1:0]           out_end_minute
);
  import sri_pkg::*;

  localparam int WSW = $bits(sri_wrap_side_t);
  localparam int LSW = $bits(sri_lvl_side_t);

  // --------------------------------------------------------------------------
  // Settings registers
  // --------------------------------------------------------------------------
  logic [3:0]        trig_modes_r;
  logic [REG_W-1:0]  start_fixed_r;
  logic [REG_W-1:0]  end_fixed_r;
  logic [REG_W-1:0]  start_offset_r;
  logic [REG_W-1:0]  end_offset_r;
  logic [REG_W-1:0]  level_pair_r;
  logic [REG_W-1:0]  ramp_up_r;
  logic [REG_W-1:0]  ramp_down_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_modes_r   <= '0;
      start_fixed_r  <= '0;
      end_fixed_r    <= '0;
      start_offset_r <= '0;
      end_offset_r   <= '0;
      level_pair_r   <= '0;
      ramp_up_r      <= '0;
      ramp_down_r    <= '0;
    end else if (cfg_we) begin
      unique case (sri_reg_t'(cfg_index))
        REG_TRIGGER_MODES: trig_modes_r   <= cfg_wdata[3:0];
        REG_START_FIXED:   start_fixed_r  <= cfg_wdata;
        REG_END_FIXED:     end_fixed_r    <= cfg_wdata;
        REG_START_OFFSET:  start_offset_r <= cfg_wdata;
        REG_END_OFFSET:    end_offset_r   <= cfg_wdata;
        REG_LEVEL_PAIR:    level_pair_r   <= cfg_wdata;
        REG_RAMP_UP:       ramp_up_r      <= cfg_wdata;
        REG_RAMP_DOWN:     ramp_down_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Resolve one trigger up to the modulo reduction.
  function automatic sri_pre_t resolve_pre(
    input sri_mode_t                mode,
    input logic [REG_W-1:0]         fixed,
    input logic signed [REG_W-1:0]  offs,
    input logic signed [SUN_W-1:0]  rise,
    input logic signed [SUN_W-1:0]  set
  );
    logic signed [SUN_W-1:0]  sun;
    logic signed [PRE_W:0]    sum;
    sri_pre_t                 res;
    sun = (mode == MODE_SUNRISE) ? rise : set;
    sum = (PRE_W+1)'(sun) + (PRE_W+1)'(offs) + (PRE_W+1)'(SUN_BIAS);
    unique case (mode) inside
      MODE_FIXED: begin
        res.ok  = (fixed < REG_W'(MIN_PER_DAY));
        res.pre = PRE_W'(fixed);
      end
      MODE_SUNRISE, MODE_SUNSET: begin
        res.ok  = !sun[SUN_W-1];
        res.pre = sum[PRE_W-1:0];
      end
      default: begin
        res.ok  = 1'b0;
        res.pre = '0;
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stage 0: input register, triggers resolved before wrapping
  // --------------------------------------------------------------------------
  logic [WRAP_CELLS:0]     wv;
  logic [WRAP_CELLS:0]     wrdy;
  logic [1:0][PRE_W-1:0]   wrem  [WRAP_CELLS+1];
  sri_wrap_side_t          wside [WRAP_CELLS+1];

  logic                    p0_valid_r;
  logic [1:0][PRE_W-1:0]   p0_rem_r;
  sri_wrap_side_t          p0_side_r;
  sri_pre_t                st_pre;
  sri_pre_t                en_pre;
  logic                    p0_rdy;

  assign st_pre = resolve_pre(sri_mode_t'(trig_modes_r[1:0]), start_fixed_r,
                              start_offset_r, in_sunrise_minute, in_sunset_minute);
  assign en_pre = resolve_pre(sri_mode_t'(trig_modes_r[3:2]), end_fixed_r,
                              end_offset_r, in_sunrise_minute, in_sunset_minute);

  assign p0_rdy   = !p0_valid_r || wrdy[0];
  assign in_ready = p0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else if (p0_rdy) begin
      p0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p0_rdy && in_valid) begin
      p0_rem_r[0]     <= st_pre.pre;
      p0_rem_r[1]     <= en_pre.pre;
      p0_side_r.now   <= in_now_minute;
      p0_side_r.st_ok <= st_pre.ok;
      p0_side_r.en_ok <= en_pre.ok;
    end
  end

  // --------------------------------------------------------------------------
  // Modulo-day reduction chain
  // --------------------------------------------------------------------------
  assign wv[0]    = p0_valid_r;
  assign wrem[0]  = p0_rem_r;
  assign wside[0] = p0_side_r;

  for (genvar g = 0; g < WRAP_CELLS; g++) begin : g_wrap
    sri_wrap_cell #(
      .SHIFT (WRAP_CELLS - 1 - g),
      .SW    (WSW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (wv[g]),
      .in_ready  (wrdy[g]),
      .in_rem    (wrem[g]),
      .in_side   (wside[g]),
      .out_valid (wv[g+1]),
      .out_ready (wrdy[g+1]),
      .out_rem   (wrem[g+1]),
      .out_side  (wside[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 1: window duration and elapsed time
  // --------------------------------------------------------------------------
  logic              p1_valid_r;
  logic              p1_ok_r;
  logic [MIN_W-1:0]  p1_dur_r;
  logic [MIN_W-1:0]  p1_el_r;
  sri_trig_t         p1_trig_r;
  logic              p1_rdy;
  logic              p2_rdy;

  logic [MIN_W-1:0]  w_st;
  logic [MIN_W-1:0]  w_en;
  logic [MIN_W-1:0]  w_now;
  logic [MIN_W:0]    dur_wrap;
  logic [MIN_W:0]    el_wrap;
  logic [MIN_W-1:0]  p1_dur_nxt;
  logic [MIN_W-1:0]  p1_el_nxt;
  sri_trig_t         p1_trig_nxt;
  logic              p1_ok_nxt;

  always_comb begin
    w_st  = wrem[WRAP_CELLS][0][MIN_W-1:0];
    w_en  = wrem[WRAP_CELLS][1][MIN_W-1:0];
    w_now = wside[WRAP_CELLS].now;
    // Differences taken modulo the day.
    dur_wrap = (w_en >= w_st)
             ? ((MIN_W+1)'(w_en) - (MIN_W+1)'(w_st))
             : ((MIN_W+1)'(w_en) + (MIN_W+1)'(MIN_PER_DAY) - (MIN_W+1)'(w_st));
    el_wrap  = (w_now >= w_st)
             ? ((MIN_W+1)'(w_now) - (MIN_W+1)'(w_st))
             : ((MIN_W+1)'(w_now) + (MIN_W+1)'(MIN_PER_DAY) - (MIN_W+1)'(w_st));
    // Equal start and end covers the whole day.
    p1_dur_nxt = (dur_wrap == '0) ? MIN_W'(MIN_PER_DAY) : dur_wrap[MIN_W-1:0];
    p1_el_nxt  = el_wrap[MIN_W-1:0];
    p1_ok_nxt  = wside[WRAP_CELLS].st_ok && wside[WRAP_CELLS].en_ok
              && (w_now < MIN_W'(MIN_PER_DAY));
    p1_trig_nxt.st_valid  = wside[WRAP_CELLS].st_ok;
    p1_trig_nxt.st_minute = wside[WRAP_CELLS].st_ok ? w_st : '0;
    p1_trig_nxt.en_valid  = wside[WRAP_CELLS].en_ok;
    p1_trig_nxt.en_minute = wside[WRAP_CELLS].en_ok ? w_en : '0;
  end

  assign p1_rdy           = !p1_valid_r || p2_rdy;
  assign wrdy[WRAP_CELLS] = p1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (p1_rdy) begin
      p1_valid_r <= wv[WRAP_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy && wv[WRAP_CELLS]) begin
      p1_ok_r   <= p1_ok_nxt;
      p1_dur_r  <= p1_dur_nxt;
      p1_el_r   <= p1_el_nxt;
      p1_trig_r <= p1_trig_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: window check, remaining time, ramp lengths clamped
  // --------------------------------------------------------------------------
  logic              p2_valid_r;
  logic              p2_off_r;
  logic              p2_end_r;
  logic [MIN_W-1:0]  p2_el_r;
  logic [MIN_W-1:0]  p2_rem_r;
  logic [MIN_W-1:0]  p2_up_r;
  logic [MIN_W-1:0]  p2_dn_r;
  sri_trig_t         p2_trig_r;
  logic              p3_rdy;

  assign p2_rdy = !p2_valid_r || p3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (p2_rdy) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_rdy && p1_valid_r) begin
      p2_off_r  <= !p1_ok_r || (p1_el_r > p1_dur_r);
      p2_end_r  <= (p1_el_r == p1_dur_r);
      p2_el_r   <= p1_el_r;
      p2_rem_r  <= p1_dur_r - p1_el_r;
      p2_up_r   <= (ramp_up_r > REG_W'(p1_dur_r)) ? p1_dur_r : ramp_up_r[MIN_W-1:0];
      p2_dn_r   <= (ramp_down_r > REG_W'(p1_dur_r)) ? p1_dur_r : ramp_down_r[MIN_W-1:0];
      p2_trig_r <= p1_trig_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: ramp selection, dividend factor and divisor
  // --------------------------------------------------------------------------
  logic              p3_valid_r;
  logic [MIN_W-1:0]  p3_n_r;
  logic [MIN_W-1:0]  p3_d_r;
  logic [PCT_W-1:0]  p3_mag_r;
  sri_lvl_side_t     p3_side_r;
  logic              p4_rdy;

  logic              use_up;
  logic              use_dn;
  logic [PCT_W-1:0]  lvl_base;
  logic [PCT_W-1:0]  lvl_tgt;
  logic [MIN_W-1:0]  p3_n_nxt;
  logic [MIN_W-1:0]  p3_d_nxt;
  logic [PCT_W-1:0]  p3_mag_nxt;
  sri_lvl_side_t     p3_side_nxt;

  always_comb begin
    lvl_tgt  = pct_clamp(level_pair_r[7:0]);
    lvl_base = pct_clamp(level_pair_r[15:8]);
    use_up   = (p2_el_r < p2_up_r);
    use_dn   = !use_up && (p2_rem_r < p2_dn_r);
    p3_n_nxt = use_up ? p2_el_r : (use_dn ? p2_rem_r : '0);
    p3_d_nxt = use_up ? p2_up_r : (use_dn ? p2_dn_r : MIN_W'(1));
    p3_side_nxt.neg  = (lvl_tgt < lvl_base);
    p3_mag_nxt       = p3_side_nxt.neg ? (lvl_base - lvl_tgt) : (lvl_tgt - lvl_base);
    p3_side_nxt.base = lvl_base;
    p3_side_nxt.tgt  = lvl_tgt;
    p3_side_nxt.trig = p2_trig_r;
    if (p2_off_r) begin
      p3_side_nxt.kind = LVL_OFF;
    end else if (p2_end_r) begin
      p3_side_nxt.kind = LVL_BASE;
    end else if (use_up || use_dn) begin
      p3_side_nxt.kind = LVL_RAMP;
    end else begin
      p3_side_nxt.kind = LVL_TARGET;
    end
  end

  assign p3_rdy = !p3_valid_r || p4_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (p3_rdy) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_rdy && p2_valid_r) begin
      p3_n_r    <= p3_n_nxt;
      p3_d_r    <= p3_d_nxt;
      p3_mag_r  <= p3_mag_nxt;
      p3_side_r <= p3_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: level difference times minutes into the ramp
  // --------------------------------------------------------------------------
  logic [DIV_CELLS:0]  dv;
  logic [DIV_CELLS:0]  drdy;
  logic [PROD_W-1:0]   drem  [DIV_CELLS+1];
  logic [MIN_W-1:0]    ddiv  [DIV_CELLS+1];
  logic [PCT_W-1:0]    dquo  [DIV_CELLS+1];
  sri_lvl_side_t       dside [DIV_CELLS+1];

  logic                p4_valid_r;
  logic [PROD_W-1:0]   p4_prod_r;
  logic [MIN_W-1:0]    p4_d_r;
  sri_lvl_side_t       p4_side_r;

  assign p4_rdy = !p4_valid_r || drdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_valid_r <= 1'b0;
    end else if (p4_rdy) begin
      p4_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p4_rdy && p3_valid_r) begin
      p4_prod_r <= PROD_W'(p3_mag_r) * PROD_W'(p3_n_r);
      p4_d_r    <= p3_d_r;
      p4_side_r <= p3_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Ramp divider chain
  // --------------------------------------------------------------------------
  assign dv[0]    = p4_valid_r;
  assign drem[0]  = p4_prod_r;
  assign ddiv[0]  = p4_d_r;
  assign dquo[0]  = '0;
  assign dside[0] = p4_side_r;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    sri_div_cell #(
      .SHIFT (DIV_CELLS - 1 - g),
      .SW    (LSW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv[g]),
      .in_ready  (drdy[g]),
      .in_rem    (drem[g]),
      .in_div    (ddiv[g]),
      .in_quo    (dquo[g]),
      .in_side   (dside[g]),
      .out_valid (dv[g+1]),
      .out_ready (drdy[g+1]),
      .out_rem   (drem[g+1]),
      .out_div   (ddiv[g+1]),
      .out_quo   (dquo[g+1]),
      .out_side  (dside[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output register: final level selection
  // --------------------------------------------------------------------------
  logic              out_valid_r;
  logic              out_active_r;
  logic [PCT_W-1:0]  out_level_r;
  sri_trig_t         out_trig_r;
  logic              out_rdy;
  logic [PCT_W-1:0]  level_nxt;
  sri_lvl_side_t     fin;
  logic [PCT_W-1:0]  fin_quo;

  always_comb begin
    fin     = dside[DIV_CELLS];
    fin_quo = dquo[DIV_CELLS];
    case (fin.kind)
      LVL_OFF:    level_nxt = '0;
      LVL_BASE:   level_nxt = fin.base;
      LVL_TARGET: level_nxt = fin.tgt;
      LVL_RAMP:   level_nxt = fin.neg ? (fin.base - fin_quo) : (fin.base + fin_quo);
      default:    level_nxt = '0;
    endcase
  end

  assign out_rdy         = !out_valid_r || out_ready;
  assign drdy[DIV_CELLS] = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= dv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv[DIV_CELLS]) begin
      out_active_r <= (fin.kind != LVL_OFF);
      out_level_r  <= level_nxt;
      out_trig_r   <= fin.trig;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_active        = out_active_r;
  assign out_level_percent = out_level_r;
  assign out_start_valid   = out_trig_r.st_valid;
  assign out_start_minute  = out_trig_r.st_minute;
  assign out_end_valid     = out_trig_r.en_valid;
  assign out_end_minute    = out_trig_r.en_minute;

endmodule

`default_nettype wire

/* design/sri_checker.sv */
// ----------------------------------------------------------------------------
// sri_checker: port-level checks on the schedule ramp intensity results
// Watches the result channel and checks relations between the result fields
// and the hold of a stalled transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sri_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_active,
  input logic [sri_pkg::PCT_W-1:0]   out_level_percent,
  input logic                        out_start_valid,
  input logic [sri_pkg::MIN_W-1:0]   out_start_minute,
  input logic                        out_end_valid,
  input logic [sri_pkg::MIN_W-1:0]   out_end_minute
);
  import sri_pkg::*;

  // An active window needs both triggers resolved.
  a_active_needs_triggers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_active |-> out_start_valid && out_end_valid)
    else $error("active result with an unresolved trigger");

  // Inactive results carry level zero; levels never exceed full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_active || out_level_percent == '0)
                  && (out_level_percent <= PCT_W'(PCT_MAX)))
    else $error("level out of range or nonzero while inactive");

  // Resolved minutes lie within the day; unresolved ones read zero.
  a_minutes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_start_valid ? (out_start_minute < MIN_W'(MIN_PER_DAY))
                                   : (out_start_minute == '0))
               && (out_end_valid ? (out_end_minute < MIN_W'(MIN_PER_DAY))
                                 : (out_end_minute == '0)))
    else $error("resolved trigger minute out of day or invalid minute nonzero");

  // A stalled result transfer holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level_percent)
                                && $stable(out_active))
    else $error("result changed while stalled");

endmodule

bind schedule_ramp_intensity sri_checker u_sri_checker (.*);

`default_nettype wire

/* tb/schedule_ramp_checker.sv */
// ----------------------------------------------------------------------------
// schedule_ramp_checker: result predictor and scoreboard for the ramp block
// Mirrors the settings registers from the configuration port, predicts the
// window state, level and resolved triggers of every query transfer, and
// compares each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module schedule_ramp_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sri_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sri_pkg::REG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [sri_pkg::MIN_W-1:0]         in_now_minute,
  input  logic signed [sri_pkg::SUN_W-1:0]  in_sunrise_minute,
  input  logic signed [sri_pkg::SUN_W-1:0]  in_sunset_minute,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_active,
  input  logic [sri_pkg::PCT_W-1:0]         out_level_percent,
  input  logic                              out_start_valid,
  input  logic [sri_pkg::MIN_W-1:0]         out_start_minute,
  input  logic                              out_end_valid,
  input  logic [sri_pkg::MIN_W-1:0]         out_end_minute,
  output int                                mismatches,
  output int                                windows_in_flight
);

  import sri_pkg::*;

  typedef struct packed {
    logic             active;
    logic [PCT_W-1:0] level;
    logic             start_valid;
    logic [MIN_W-1:0] st_min;
    logic             end_valid;
    logic [MIN_W-1:0] en_min;
  } window_result_t;

  // Local copy of the settings registers.
  logic [3:0]       trig_modes;
  logic [REG_W-1:0] start_fixed;
  logic [REG_W-1:0] end_fixed;
  logic [REG_W-1:0] start_off;
  logic [REG_W-1:0] end_off;
  logic [REG_W-1:0] level_pair;
  logic [REG_W-1:0] ramp_up;
  logic [REG_W-1:0] ramp_dn;

  window_result_t predicted_windows[$];
  int             mismatch_count = 0;

  // Reduce any minute count into the day, never negative.
  function automatic int wrap_day(input int v);
    int r;
    r = v % MIN_PER_DAY;
    if (r < 0) r += MIN_PER_DAY;
    return r;
  endfunction

  // Resolved trigger minute, or -1 when the trigger cannot be resolved.
  function automatic int resolve_trigger(input sri_mode_t mode,
                                         input logic [REG_W-1:0] fixed_min,
                                         input logic [REG_W-1:0] offset_raw,
                                         input int dawn, input int dusk);
    int shift;
    shift = int'($signed(offset_raw));
    case (mode)
      MODE_FIXED:   return (fixed_min < MIN_PER_DAY) ? int'(fixed_min) : -1;
      MODE_SUNRISE: return (dawn >= 0) ? wrap_day(dawn + shift) : -1;
      MODE_SUNSET:  return (dusk >= 0) ? wrap_day(dusk + shift) : -1;
      default:      return -1;
    endcase
  endfunction

  // Level inside the window, or -1 when the window is not active.
  function automatic int window_level(input int now_min, input int st, input int en);
    int span, elapsed, remain, tgt, base, up_len, down_len;
    if (now_min >= MIN_PER_DAY || st < 0 || en < 0) return -1;
    span = wrap_day(en - st);
    // Equal start and end cover the whole day.
    if (span == 0) span = MIN_PER_DAY;
    elapsed = wrap_day(now_min - st);
    tgt  = (level_pair[7:0] > PCT_MAX) ? PCT_MAX : int'(level_pair[7:0]);
    base = (level_pair[15:8] > PCT_MAX) ? PCT_MAX : int'(level_pair[15:8]);
    if (elapsed > span) return -1;
    // The last minute of the window sits at the base level.
    if (elapsed == span) return base;
    up_len   = (int'(ramp_up) > span) ? span : int'(ramp_up);
    down_len = (int'(ramp_dn) > span) ? span : int'(ramp_dn);
    if (up_len > 0 && elapsed < up_len) return base + ((tgt - base) * elapsed) / up_len;
    remain = span - elapsed;
    if (down_len > 0 && remain < down_len) return base + ((tgt - base) * remain) / down_len;
    return tgt;
  endfunction

  function automatic window_result_t predict_window(input logic [MIN_W-1:0] now_min,
                                                    input logic signed [SUN_W-1:0] rise_min,
                                                    input logic signed [SUN_W-1:0] set_min);
    window_result_t r;
    int dawn, dusk, st, en, lv;
    dawn = rise_min;
    dusk = set_min;
    st = resolve_trigger(sri_mode_t'(trig_modes[1:0]), start_fixed, start_off, dawn, dusk);
    en = resolve_trigger(sri_mode_t'(trig_modes[3:2]), end_fixed, end_off, dawn, dusk);
    lv = window_level(int'(now_min), st, en);
    r.active      = (lv >= 0);
    r.level       = (lv >= 0) ? PCT_W'(lv) : '0;
    r.start_valid = (st >= 0);
    r.st_min      = (st >= 0) ? MIN_W'(st) : '0;
    r.end_valid   = (en >= 0);
    r.en_min      = (en >= 0) ? MIN_W'(en) : '0;
    return r;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Track settings writes, score result transfers, queue new predictions.
  always @(posedge clk) begin : scoreboard
    window_result_t want;
    if (!rst_n) begin
      trig_modes  = '0;
      start_fixed = '0;
      end_fixed   = '0;
      start_off   = '0;
      end_off     = '0;
      level_pair  = '0;
      ramp_up     = '0;
      ramp_dn     = '0;
      predicted_windows.delete();
    end else begin
      if (cfg_we) begin
        case (sri_reg_t'(cfg_index))
          REG_TRIGGER_MODES: trig_modes  = cfg_wdata[3:0];
          REG_START_FIXED:   start_fixed = cfg_wdata;
          REG_END_FIXED:     end_fixed   = cfg_wdata;
          REG_START_OFFSET:  start_off   = cfg_wdata;
          REG_END_OFFSET:    end_off     = cfg_wdata;
          REG_LEVEL_PAIR:    level_pair  = cfg_wdata;
          REG_RAMP_UP:       ramp_up     = cfg_wdata;
          REG_RAMP_DOWN:     ramp_dn     = cfg_wdata;
        endcase
      end
      if (out_valid && out_ready) begin
        if (predicted_windows.size() == 0) begin
          $error("result transfer with no query outstanding");
          mismatch_count++;
        end else begin
          want = predicted_windows.pop_front();
          compare_field("active", want.active, out_active);
          compare_field("level_percent", want.level, out_level_percent);
          compare_field("start_valid", want.start_valid, out_start_valid);
          compare_field("start_minute", want.st_min, out_start_minute);
          compare_field("end_valid", want.end_valid, out_end_valid);
          compare_field("end_minute", want.en_min, out_end_minute);
        end
      end
      if (in_valid && in_ready) begin
        predicted_windows.push_back(predict_window(in_now_minute, in_sunrise_minute,
                                                   in_sunset_minute));
      end
    end
    windows_in_flight <= predicted_windows.size();
    mismatches        <= mismatch_count;
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench top for the schedule ramp intensity block
// Writes settings while the pipeline is empty, sends directed queries over
// the trigger modes, window edges and ramps, then phases of random queries
// under random settings with random sender gaps and receiver stalls. The
// checker scores every result; this module reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import sri_pkg::*;

  localparam int DRAIN_CYCLES = 24;    // pipeline latency plus margin
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [IDX_W-1:0]         cfg_index;
  logic [REG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [MIN_W-1:0]         in_now_minute;
  logic signed [SUN_W-1:0]  in_sunrise_minute;
  logic signed [SUN_W-1:0]  in_sunset_minute;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_active;
  logic [PCT_W-1:0]         out_level_percent;
  logic                     out_start_valid;
  logic [MIN_W-1:0]         out_start_minute;
  logic                     out_end_valid;
  logic [MIN_W-1:0]         out_end_minute;

  int mismatches;
  int windows_in_flight;
  int quiet_cycles = 0;
  int gap_max      = 3;
  int stall_max    = 3;

  // Fixed trigger minutes last written, used to aim queries at window edges.
  logic [REG_W-1:0] cur_start_fixed = '0;
  logic [REG_W-1:0] cur_end_fixed   = '0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  schedule_ramp_intensity u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_minute     (in_now_minute),
    .in_sunrise_minute (in_sunrise_minute),
    .in_sunset_minute  (in_sunset_minute),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_active        (out_active),
    .out_level_percent (out_level_percent),
    .out_start_valid   (out_start_valid),
    .out_start_minute  (out_start_minute),
    .out_end_valid     (out_end_valid),
    .out_end_minute    (out_end_minute)
  );

  schedule_ramp_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_minute     (in_now_minute),
    .in_sunrise_minute (in_sunrise_minute),
    .in_sunset_minute  (in_sunset_minute),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_active        (out_active),
    .out_level_percent (out_level_percent),
    .out_start_valid   (out_start_valid),
    .out_start_minute  (out_start_minute),
    .out_end_valid     (out_end_valid),
    .out_end_minute    (out_end_minute),
    .mismatches        (mismatches),
    .windows_in_flight (windows_in_flight)
  );

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result receiver: stall a random number of cycles before each transfer.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(input sri_reg_t idx, input logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all eight settings registers back to back.
  task automatic apply_settings(input logic [3:0] modes,
                                input logic [REG_W-1:0] start_fix, end_fix,
                                input logic [REG_W-1:0] start_shift, end_shift,
                                input logic [REG_W-1:0] levels,
                                input logic [REG_W-1:0] up_len, down_len);
    write_reg(REG_TRIGGER_MODES, REG_W'(modes));
    write_reg(REG_START_FIXED, start_fix);
    write_reg(REG_END_FIXED, end_fix);
    write_reg(REG_START_OFFSET, start_shift);
    write_reg(REG_END_OFFSET, end_shift);
    write_reg(REG_LEVEL_PAIR, levels);
    write_reg(REG_RAMP_UP, up_len);
    write_reg(REG_RAMP_DOWN, down_len);
    cfg_we          <= 1'b0;
    cur_start_fixed = start_fix;
    cur_end_fixed   = end_fix;
  endtask

  // Stop sending and let every outstanding result drain out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (windows_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One query transfer after a random gap; valid stays high until accepted.
  task automatic send_query(input logic [MIN_W-1:0] now_min,
                            input logic signed [SUN_W-1:0] dawn,
                            input logic signed [SUN_W-1:0] dusk);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_now_minute     <= now_min;
    in_sunrise_minute <= dawn;
    in_sunset_minute  <= dusk;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [REG_W-1:0] pick_minute();
    case ($urandom_range(0, 9))
      0:       return REG_W'(MIN_PER_DAY);
      1:       return '1;
      2:       return REG_W'($urandom_range(0, 65535));
      3:       return '0;
      4:       return REG_W'(MIN_PER_DAY - 1);
      default: return REG_W'($urandom_range(0, MIN_PER_DAY - 1));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;  // most negative offset
      1:       return 16'h7FFF;  // most positive offset
      2:       return REG_W'($urandom_range(0, 65535));
      default: return REG_W'(int'($urandom_range(0, 1440)) - 720);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_ramp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return REG_W'($urandom_range(0, 65535));
      default: return REG_W'($urandom_range(0, 600));
    endcase
  endfunction

  // Mostly resolvable triggers and in-range levels, sometimes anything.
  task automatic choose_settings();
    logic [3:0]       modes;
    logic [REG_W-1:0] levels;
    if ($urandom_range(0, 7) == 0) begin
      modes = 4'($urandom_range(0, 15));
    end else begin
      modes = {2'($urandom_range(0, 2)), 2'($urandom_range(0, 2))};
    end
    case ($urandom_range(0, 7))
      0:       levels = '1;
      1:       levels = REG_W'($urandom_range(0, 65535));
      default: levels = {8'($urandom_range(0, PCT_MAX)), 8'($urandom_range(0, PCT_MAX))};
    endcase
    apply_settings(modes, pick_minute(), pick_minute(), pick_offset(), pick_offset(),
                   levels, pick_ramp(), pick_ramp());
  endtask

  // Mostly in-day queries with known sun times; some aimed at the fixed
  // window edges, some with an unknown sun time, some with raw field bits.
  task automatic send_random_query();
    int                      kind;
    logic [REG_W-1:0]        mark;
    logic [MIN_W-1:0]        now_min;
    logic signed [SUN_W-1:0] dawn;
    logic signed [SUN_W-1:0] dusk;
    kind    = $urandom_range(0, 9);
    now_min = MIN_W'($urandom_range(0, MIN_PER_DAY - 1));
    dawn    = SUN_W'($urandom_range(0, MIN_PER_DAY - 1));
    dusk    = SUN_W'($urandom_range(0, MIN_PER_DAY - 1));
    case (kind)
      6: begin
        mark    = $urandom_range(0, 1) ? cur_start_fixed : cur_end_fixed;
        now_min = MIN_W'((int'(mark) + int'($urandom_range(0, 4)) + MIN_PER_DAY - 2)
                         % MIN_PER_DAY);
      end
      7: begin
        if ($urandom_range(0, 1)) dawn = SUN_W'(-int'($urandom_range(1, 2048)));
        else dusk = SUN_W'(-int'($urandom_range(1, 2048)));
      end
      8, 9: begin
        now_min = MIN_W'($urandom_range(0, 2047));
        dawn    = SUN_W'($urandom_range(0, 4095));
        dusk    = SUN_W'($urandom_range(0, 4095));
      end
      default: ;
    endcase
    send_query(now_min, dawn, dusk);
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_valid          <= 1'b0;
    in_now_minute     <= '0;
    in_sunrise_minute <= '0;
    in_sunset_minute  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Fixed window 06:00 to 18:00 with both ramps; walk across its edges.
    wait_idle();
    apply_settings({MODE_FIXED, MODE_FIXED}, 16'd360, 16'd1080, 16'd0, 16'd0,
                   {8'd10, 8'd90}, 16'd60, 16'd120);
    send_query(0, -1, -1);
    send_query(359, 2047, -2048);
    send_query(360, 0, 0);
    send_query(390, 1439, 1439);
    send_query(420, 100, 200);
    send_query(1000, -1, 500);
    send_query(1079, 500, -1);
    send_query(1080, 300, 1100);
    send_query(1081, 300, 1100);
    send_query(1439, 300, 1100);
    send_query(1440, 300, 1100);
    send_query(2047, 300, 1100);

    // Sun triggers with extreme offsets, clamped target, oversized ramps.
    wait_idle();
    apply_settings({MODE_SUNSET, MODE_SUNRISE}, 16'd0, 16'd0, 16'h8000, 16'h7FFF,
                   {8'd0, 8'hFF}, 16'hFFFF, 16'hFFFF);
    send_query(500, 400, 1200);
    send_query(100, -1, 1200);
    send_query(100, 400, -2048);
    send_query(2047, 2047, 2047);

    // Overnight window from sunset to sunrise, falling ramp from base to target.
    wait_idle();
    apply_settings({MODE_SUNRISE, MODE_SUNSET}, 16'd0, 16'd0, 16'd0, 16'd0,
                   {8'd90, 8'd5}, 16'd100, 16'd100);
    send_query(1250, 360, 1200);
    send_query(1439, 360, 1200);
    send_query(0, 360, 1200);
    send_query(300, 360, 1200);

    // Start equal to end covers the whole day.
    wait_idle();
    apply_settings({MODE_FIXED, MODE_FIXED}, 16'd700, 16'd700, 16'd0, 16'd0,
                   {8'd20, 8'd80}, 16'd0, 16'd0);
    send_query(700, 10, 20);
    send_query(699, 10, 20);

    // Invalid mode on both triggers.
    wait_idle();
    apply_settings({MODE_INVALID, MODE_INVALID}, 16'd100, 16'd200, 16'd0, 16'd0,
                   {8'd20, 8'd80}, 16'd10, 16'd10);
    send_query(150, 100, 200);

    // Fixed minutes outside the day.
    wait_idle();
    apply_settings({MODE_FIXED, MODE_FIXED}, 16'd1440, 16'hFFFF, 16'd0, 16'd0,
                   {8'd20, 8'd80}, 16'd10, 16'd10);
    send_query(150, 100, 200);

    // Random phases, each under fresh settings and its own idling pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      choose_settings();
      gap_max   = (phase % 3 == 1) ? 0 : 15;
      stall_max = (phase % 4 == 2) ? 0 : 15;
      repeat (PHASE_ITEMS) send_random_query();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
